// ===== rtl/scfr_pkg.sv =====
// ----------------------------------------------------------------------------
// scfr_pkg
// Shared types, constants and result codes of the serial CAN frame receiver.
// ----------------------------------------------------------------------------
package scfr_pkg;

  // capacity of the frame buffer in bytes (20 to 64)
  localparam int BUFFER_BYTES = 32;

  localparam int BYTE_W   = 8;
  localparam int COUNT_W  = 6;
  localparam int LIMIT_W  = 7;
  localparam int STATUS_W = 3;
  localparam int HEADER_W = 16;
  localparam int DLC_W    = 4;
  localparam int BODY_W   = 64;
  localparam int BODY_LANES = BODY_W / BYTE_W;

  localparam logic [LIMIT_W-1:0] BUFFER_LIMIT = LIMIT_W'(BUFFER_BYTES);
  localparam logic [COUNT_W-1:0] MAX_LEN_RESET = 6'd32;

  // protocol bytes
  localparam logic [BYTE_W-1:0] SYNC_BYTE    = 8'hAA;
  localparam logic [BYTE_W-1:0] CMD_TYPE     = 8'h55;
  localparam logic [3:0]        DATA_NIBBLE  = 4'hC;

  // byte positions within a frame
  localparam logic [COUNT_W-1:0] POS_TYPE      = 6'd1;
  localparam logic [COUNT_W-1:0] POS_HDR_LO    = 6'd2;
  localparam logic [COUNT_W-1:0] POS_HDR_HI    = 6'd3;
  localparam logic [COUNT_W-1:0] POS_BODY      = 6'd4;
  localparam logic [COUNT_W-1:0] POS_SUM_FIRST = 6'd2;
  localparam logic [COUNT_W-1:0] POS_SUM_LAST  = 6'd18;
  localparam logic [COUNT_W-1:0] CMD_FRAME_BYTES = 6'd20;
  localparam logic [COUNT_W-1:0] DATA_OVERHEAD = 6'd5;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_DATA     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_CMD_OK   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_CSUM_ERR = 3'd2;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd4;

  // registered byte request between input stage and parser
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] rx_byte;
  } byte_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  frame_length;
    logic [HEADER_W-1:0] header_word;
    logic [DLC_W-1:0]    dlc;
    logic [BODY_W-1:0]   body_bytes;
  } result_t;

endpackage

// ===== rtl/scfr_in_if.sv =====
// ----------------------------------------------------------------------------
// scfr_in_if
// Byte request channel: valid, ready and one received byte.
// ----------------------------------------------------------------------------
interface scfr_in_if;
  import scfr_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/scfr_out_if.sv =====
// ----------------------------------------------------------------------------
// scfr_out_if
// Frame result channel: valid, ready and the fields of one completed frame.
// ----------------------------------------------------------------------------
interface scfr_out_if;
  import scfr_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  frame_length;
  logic [HEADER_W-1:0] header_word;
  logic [DLC_W-1:0]    dlc;
  logic [BODY_W-1:0]   body_bytes;

  modport source (output valid, output status, output frame_length, output header_word,
                  output dlc, output body_bytes, input ready);
  modport sink   (input valid, input status, input frame_length, input header_word,
                  input dlc, input body_bytes, output ready);
endinterface

// ===== rtl/scfr_in_stage.sv =====
// ----------------------------------------------------------------------------
// scfr_in_stage
// Input register: holds one received byte until the parser takes it.
// ----------------------------------------------------------------------------
module scfr_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  scfr_in_if.sink             in_rx,
  input  logic                take,
  output scfr_pkg::byte_req_t req
);
  import scfr_pkg::*;

  logic              valid_r, valid_nxt;
  logic [BYTE_W-1:0] byte_r;
  logic              load;

  // register is free when empty or being drained this cycle
  assign in_rx.ready = !valid_r || take;
  assign load        = in_rx.valid && in_rx.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= in_rx.rx_byte;
    end
  end

  assign req.valid   = valid_r;
  assign req.rx_byte = byte_r;
endmodule

// ===== rtl/scfr_parser.sv =====
// ----------------------------------------------------------------------------
// scfr_parser
// Frame state, per-byte framing decision and the result register.
// ----------------------------------------------------------------------------
module scfr_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  scfr_pkg::byte_req_t           req,
  output logic                          take,
  input  logic [scfr_pkg::COUNT_W-1:0]  max_frame_len,
  scfr_out_if.source                    out_res
);
  import scfr_pkg::*;

  logic [COUNT_W-1:0]  count_r, count_nxt;
  logic [BYTE_W-1:0]   type_r, type_nxt;
  logic [BYTE_W-1:0]   sum_r, sum_nxt;
  logic [HEADER_W-1:0] hdr_r, hdr_nxt;
  logic [BODY_W-1:0]   body_r, body_nxt;

  logic                out_valid_r, out_valid_nxt;
  result_t             res_r, res_nxt;

  logic [LIMIT_W-1:0]  limit;
  logic                overflow;
  logic                emit;
  logic [STATUS_W-1:0] status;
  logic [BYTE_W-1:0]   b;
  logic [COUNT_W-1:0]  data_end;

  assign b = req.rx_byte;

  // one byte per cycle as long as the result slot is free or draining
  assign take = req.valid && (!out_valid_r || out_res.ready);

  assign limit = ({1'b0, max_frame_len} > BUFFER_LIMIT) ? BUFFER_LIMIT
                                                        : {1'b0, max_frame_len};
  assign overflow = ({1'b0, count_r} >= limit);

  // state after taking the byte
  always_comb begin
    count_nxt = count_r + 1'b1;
    type_nxt  = (count_r == POS_TYPE) ? b : type_r;
    hdr_nxt   = hdr_r;
    if (count_r == POS_HDR_LO) begin
      hdr_nxt[BYTE_W-1:0] = b;
    end
    if (count_r == POS_HDR_HI) begin
      hdr_nxt[HEADER_W-1:BYTE_W] = b;
    end
    body_nxt = body_r;
    for (int k = 0; k < BODY_LANES; k++) begin
      if (count_r == POS_BODY + COUNT_W'(k)) begin
        body_nxt[k*BYTE_W +: BYTE_W] = b;
      end
    end
    sum_nxt = sum_r;
    if (count_r >= POS_SUM_FIRST && count_r <= POS_SUM_LAST) begin
      sum_nxt = sum_r + b;
    end
  end

  assign data_end = {2'b00, type_nxt[DLC_W-1:0]} + DATA_OVERHEAD;

  // framing decision
  always_comb begin
    emit   = 1'b0;
    status = ST_UNKNOWN;
    if (overflow) begin
      emit   = 1'b1;
      status = ST_OVERFLOW;
    end else if (count_r == '0) begin
      emit   = (b != SYNC_BYTE);
      status = ST_UNKNOWN;
    end else if (type_nxt == CMD_TYPE) begin
      emit   = (count_nxt >= CMD_FRAME_BYTES);
      status = (b == sum_nxt) ? ST_CMD_OK : ST_CSUM_ERR;
    end else if (type_nxt[BYTE_W-1:DLC_W] == DATA_NIBBLE) begin
      emit   = (count_nxt >= data_end);
      status = ST_DATA;
    end else begin
      emit   = 1'b1;
      status = ST_UNKNOWN;
    end
  end

  always_comb begin
    res_nxt.status = status;
    if (overflow) begin
      res_nxt.frame_length = count_r;
      res_nxt.header_word  = hdr_r;
      res_nxt.dlc          = type_r[DLC_W-1:0];
      res_nxt.body_bytes   = body_r;
    end else begin
      res_nxt.frame_length = count_nxt;
      res_nxt.header_word  = hdr_nxt;
      res_nxt.dlc          = type_nxt[DLC_W-1:0];
      res_nxt.body_bytes   = body_nxt;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_res.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      type_r      <= '0;
      sum_r       <= '0;
      hdr_r       <= '0;
      body_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        if (emit) begin
          // frame done, start empty
          count_r <= '0;
          type_r  <= '0;
          sum_r   <= '0;
          hdr_r   <= '0;
          body_r  <= '0;
        end else begin
          count_r <= count_nxt;
          type_r  <= type_nxt;
          sum_r   <= sum_nxt;
          hdr_r   <= hdr_nxt;
          body_r  <= body_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      res_r <= res_nxt;
    end
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.status       = res_r.status;
  assign out_res.frame_length = res_r.frame_length;
  assign out_res.header_word  = res_r.header_word;
  assign out_res.dlc          = res_r.dlc;
  assign out_res.body_bytes   = res_r.body_bytes;
endmodule

// ===== rtl/serial_can_frame_receiver_top.sv =====
// ----------------------------------------------------------------------------
// serial_can_frame_receiver_top
// Frames the byte stream of a serial CAN adapter into command, data,
// unknown and overflow results.
// ----------------------------------------------------------------------------
//
//  channel   direction  payload                                   handshake
//  in_rx     in         rx_byte[7:0]                              valid/ready
//  out_res   out        status, frame_length, header_word, dlc,   valid/ready
//                       body_bytes[63:0]
//  cfg       in         cfg_data[5:0] (max_frame_len)             cfg_we only
//
// one byte request per cycle unless the result stalls; a byte waits in the
//   input register, the frame logic decides and loads the result register
// the result of a frame's last byte is valid in the cycle after that byte
//   is taken, so the sink can take it at the following edge
// a stalled result holds the result register; the input register takes at
//   most one more byte, after that in_rx.ready drops until the result drains
// synchronous active-low reset clears the frame state, both valid flags and
//   sets max_frame_len to 32
//
module serial_can_frame_receiver_top (
  input  logic                         clk,
  input  logic                         rst_n,
  scfr_in_if.sink                      in_rx,
  scfr_out_if.source                   out_res,
  input  logic                         cfg_we,
  input  logic [scfr_pkg::COUNT_W-1:0] cfg_data
);
  import scfr_pkg::*;

  // buffer capacity; user writes it only while the block is idle (unchecked)
  logic [COUNT_W-1:0] max_frame_len_r;

  byte_req_t req;
  logic      take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_frame_len_r <= MAX_LEN_RESET;
    end else if (cfg_we) begin
      max_frame_len_r <= cfg_data;
    end
  end

  // input register: decouples the byte source from the frame logic
  scfr_in_stage u_in_stage (
    .clk   (clk),
    .rst_n (rst_n),
    .in_rx (in_rx),
    .take  (take),
    .req   (req)
  );

  // frame state, compare/add decision and result register
  scfr_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .req           (req),
    .take          (take),
    .max_frame_len (max_frame_len_r),
    .out_res       (out_res)
  );
endmodule
